/* src/sat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sat_pkg;

  localparam int DEPTH      = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int ID_W       = 32;
  localparam int EDGE_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = 7;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int S_DATA_W   = ID_W + EDGE_W;
  localparam int M_DATA_W   = ((STATUS_W + ENTRY_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_DATA_W - STATUS_W - ENTRY_W;

  // hit detection: OR of per-cell match flags, registered in groups
  localparam int GRP        = 8;
  localparam int NGRP       = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_APPLY
  } state_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic                  compare;
    logic                  ins;
    logic                  rem;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } cell_cmd_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic                  valid;
    logic                  lt;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } cell_data_t;

endpackage
`default_nettype wire

/* src/sat_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module sat_cell import sat_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire cell_cmd_t  cmd,
  input  wire cell_data_t left,
  input  wire cell_data_t right,
  output cell_data_t      cur,
  output logic            eq
);

  logic                  valid;
  logic                  lt;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] val;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (cmd.compare) begin
        lt <= valid && (key < cmd.key);
        eq <= valid && (key == cmd.key);
      end
      if (cmd.ins && !lt) begin
        valid <= valid | left.valid;
      end else if (cmd.rem && !lt) begin
        valid <= right.valid;
      end
    end
  end

  // entries at or above the ordered position move; the cell at that position takes the new entry
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      if (left.lt) begin
        key <= cmd.key;
        val <= cmd.val;
      end else begin
        key <= left.key;
        val <= left.val;
      end
    end else if (cmd.rem && !lt) begin
      key <= right.key;
      val <= right.val;
    end
  end

  assign cur.valid = valid;
  assign cur.lt    = lt;
  assign cur.key   = key;
  assign cur.val   = val;

endmodule
`default_nettype wire

/* src/sat_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module sat_ctrl import sat_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  wire               func,
  input  wire  [ID_W-1:0]   neighbor_id,
  input  wire  [EDGE_W-1:0] edge_number,
  input  wire  [DEPTH-1:0]  eq,
  output cell_cmd_t         cmd,
  output logic              m_tvalid,
  input  wire               m_tready,
  output status_t           status,
  output logic [CNT_W-1:0]  count
);

  state_t                state;
  state_t                state_next;
  logic                  op_rem;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] val;
  logic [NGRP-1:0]       grp;
  logic [NGRP-1:0]       grp_next;
  logic                  hit;
  logic                  full;
  logic                  apply_go;
  status_t               status_next;
  logic [CNT_W-1:0]      count_next;

  always_comb begin
    grp_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < DEPTH) begin
          grp_next[g] = grp_next[g] | eq[g * GRP + j];
        end
      end
    end
  end

  assign hit      = |grp;
  assign full     = (count == CNT_W'(DEPTH));
  assign apply_go = (state == S_APPLY) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = s_tvalid ? S_CMP : S_IDLE;
      S_CMP:   state_next = S_RED;
      S_RED:   state_next = S_APPLY;
      S_APPLY: state_next = apply_go ? S_IDLE : S_APPLY;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == S_IDLE);
    cmd.compare = (state == S_CMP);
    cmd.ins     = apply_go && !op_rem && !hit && !full;
    cmd.rem     = apply_go && op_rem && hit;
    cmd.key     = key;
    cmd.val     = val;
  end

  always_comb begin
    status_next = ST_INSERTED;
    count_next  = count;
    priority if (op_rem && hit) begin
      status_next = ST_REMOVED;
      count_next  = count - CNT_W'(1);
    end else if (op_rem) begin
      status_next = ST_NOT_FOUND;
    end else if (hit) begin
      status_next = ST_DUPLICATE;
    end else if (full) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_INSERTED;
      count_next  = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        m_tvalid <= 1'b1;
        count    <= count_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_rem <= func;
      key    <= KEY_BITS'(neighbor_id);
      val    <= VALUE_BITS'(edge_number);
    end
    if (state == S_RED) begin
      grp <= grp_next;
    end
    if (apply_go) begin
      status <= status_next;
    end
  end

endmodule
`default_nettype wire

/* src/sorted_adjacency_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sorted adjacency list: up to DEPTH (neighbour id, edge id) entries kept in
// ascending neighbour id order in a row of cells, one entry per cell.
// Input channel s_*: tdata = neighbour id, edge id; tuser = 0 insert, 1 remove.
// Output channel m_*: one transaction per input, carrying a status code
// (inserted, duplicate, removed, not found, full) and the entry count after
// the operation.
// Each input passes through capture, compare in every cell, registered OR
// of the per-cell match flags, then the shift of the row by one place. The
// result is registered at the same edge as the shift; the shift waits while
// an earlier result is still held on m_tready. A new input is taken once the
// row is back to idle, so one input is finished before the next is taken.
// The OR tree of match flags sets the middle step.
// A result waiting on m_tready does not stop the next input being taken;
// that input's shift step waits until the output register is free.
// Reset empties the table at once (valid flags and count cleared).
module sorted_adjacency_table import sat_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [S_DATA_W-1:0] s_tdata,  // neighbor_id, edge_number
  input  wire                 s_tuser,  // func
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // status, entry_count, zero pad
);

  cell_cmd_t        cmd;
  cell_data_t       cdata [DEPTH];
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] vld;
  status_t          status;
  logic [CNT_W-1:0] count;
  cell_data_t       head;
  cell_data_t       tail;

  // virtual entry below the first cell: valid and below any key
  assign head = '{valid: 1'b1, lt: 1'b1, key: '0, val: '0};
  assign tail = '{valid: 1'b0, lt: 1'b0, key: '0, val: '0};

  sat_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .func        (s_tuser),
    .neighbor_id (s_tdata[ID_W-1:0]),
    .edge_number (s_tdata[ID_W +: EDGE_W]),
    .eq          (eq),
    .cmd         (cmd),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .status      (status),
    .count       (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_data_t left;
    cell_data_t right;
    if (i == 0) begin : g_head
      assign left = head;
    end else begin : g_left
      assign left = cdata[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = tail;
    end else begin : g_right
      assign right = cdata[i+1];
    end
    sat_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .cur   (cdata[i]),
      .eq    (eq[i])
    );
    assign vld[i] = cdata[i].valid;
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, ENTRY_W'(count), status};

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(count))
    else $error("valid cells disagree with entry count");

  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH-1:1] & ~vld[DEPTH-2:0]) == '0)
    else $error("valid cells not a contiguous prefix");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while one is in progress");

endmodule
`default_nettype wire

/* sim/adjacency_table_checker.sv */
`timescale 1ns / 1ps
// Watches both channels of the sorted adjacency table, keeps its own sorted
// copy of the table and checks every output transaction in order.
module adjacency_table_checker import sat_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  input  wire                 s_tready,
  input  wire  [S_DATA_W-1:0] s_tdata,  // neighbor_id, edge_number
  input  wire                 s_tuser,  // func
  input  wire                 m_tvalid,
  input  wire                 m_tready,
  input  wire  [M_DATA_W-1:0] m_tdata,  // status, entry_count, zero pad
  output int                  fail_count,
  output int                  pending,
  output int                  accepted_in,
  output int                  n_inserted,
  output int                  n_duplicate,
  output int                  n_removed,
  output int                  n_not_found,
  output int                  n_full,
  output int                  peak_fill
);

  typedef struct {
    status_t            st;
    logic [ENTRY_W-1:0] cnt;
  } outcome_t;

  logic [KEY_BITS-1:0]   row_keys  [DEPTH];
  logic [VALUE_BITS-1:0] row_edges [DEPTH];
  int                    row_fill;
  outcome_t              awaited_outcomes [$];

  // one insert or remove on the sorted row, as the block should do it
  task automatic apply_table_op(input logic remove, input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] edge_id,
                                output outcome_t res);
    int pos;
    int i;
    bit hit;
    pos = 0;
    while (pos < row_fill && row_keys[pos] < key) pos++;
    hit = (pos < row_fill) && (row_keys[pos] == key);
    if (!remove) begin
      // duplicate wins over full
      if (hit) begin
        res.st = ST_DUPLICATE;
      end else if (row_fill >= DEPTH) begin
        res.st = ST_FULL;
      end else begin
        for (i = row_fill; i > pos; i--) begin
          row_keys[i]  = row_keys[i-1];
          row_edges[i] = row_edges[i-1];
        end
        row_keys[pos]  = key;
        row_edges[pos] = edge_id;
        row_fill++;
        res.st = ST_INSERTED;
      end
    end else if (hit) begin
      for (i = pos; i < row_fill - 1; i++) begin
        row_keys[i]  = row_keys[i+1];
        row_edges[i] = row_edges[i+1];
      end
      row_fill--;
      res.st = ST_REMOVED;
    end else begin
      res.st = ST_NOT_FOUND;
    end
    res.cnt = row_fill[ENTRY_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    outcome_t            res;
    outcome_t            want;
    logic [STATUS_W-1:0] got_st;
    logic [ENTRY_W-1:0]  got_cnt;
    if (rst) begin
      row_fill    = 0;
      awaited_outcomes.delete();
      fail_count  = 0;
      pending     = 0;
      accepted_in = 0;
      n_inserted  = 0;
      n_duplicate = 0;
      n_removed   = 0;
      n_not_found = 0;
      n_full      = 0;
      peak_fill   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_table_op(s_tuser, s_tdata[KEY_BITS-1:0], s_tdata[ID_W +: VALUE_BITS], res);
        awaited_outcomes.push_back(res);
        accepted_in++;
        if (row_fill > peak_fill) peak_fill = row_fill;
        case (res.st)
          ST_INSERTED:  n_inserted++;
          ST_DUPLICATE: n_duplicate++;
          ST_REMOVED:   n_removed++;
          ST_NOT_FOUND: n_not_found++;
          default:      n_full++;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got_st  = m_tdata[STATUS_W-1:0];
        got_cnt = m_tdata[STATUS_W +: ENTRY_W];
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result, status %0d count %0d", $time, got_st, got_cnt);
          fail_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got_st !== want.st) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.st, got_st);
            fail_count++;
          end
          if (got_cnt !== want.cnt) begin
            $display("%0t: entry count mismatch, expected %0d, actual %0d",
                     $time, want.cnt, got_cnt);
            fail_count++;
          end
        end
      end
      pending = awaited_outcomes.size();
    end
  end

endmodule

/* sim/sorted_adjacency_table_tb.sv */
`timescale 1ns / 1ps
module sorted_adjacency_table_tb;
  import sat_pkg::*;

  localparam logic OP_INSERT    = 1'b0;
  localparam logic OP_REMOVE    = 1'b1;
  localparam int   POOL         = 80;
  localparam int   PHASE_ITEMS  = 140;
  localparam int   HOLD_OFF     = 400;
  localparam int   HOLD_AT      = 300;
  localparam int   DRAIN_CYCLES = 16;
  localparam int   CYCLE_LIMIT  = 500000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;  // neighbor_id, edge_number
  logic                s_tuser  = 1'b0;  // func
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;  // status, entry_count, zero pad

  int fail_count, pending, accepted_in, peak_fill;
  int n_inserted, n_duplicate, n_removed, n_not_found, n_full;
  int cycles = 0;
  bit no_gaps = 1'b0;

  logic [KEY_BITS-1:0] key_pool [POOL];
  phase_kind_t         plan [8] = '{PH_FILL, PH_DRAIN, PH_FILL, PH_MIXED,
                                    PH_DRAIN, PH_FILL, PH_MIXED, PH_DRAIN};

  sorted_adjacency_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  adjacency_table_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .accepted_in (accepted_in),
    .n_inserted  (n_inserted),
    .n_duplicate (n_duplicate),
    .n_removed   (n_removed),
    .n_not_found (n_not_found),
    .n_full      (n_full),
    .peak_fill   (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called and returning at a falling edge
  task automatic offer(input logic op, input logic [KEY_BITS-1:0] key,
                       input logic [VALUE_BITS-1:0] edge_id);
    int n;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {edge_id, key};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    n = no_gaps ? 0 : pick_gap();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // output side: random ready, plus one long hold-off to back the block up
  initial begin : rx_side
    int  n;
    bit  held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && accepted_in >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (n) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int                    p;
    int                    k;
    int                    r;
    int                    idx;
    logic                  op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] edge_id;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (k = 4; k < POOL; k++)
      key_pool[k] = (k < 40) ? $urandom_range(0, 255) : $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, both ends of the key range, duplicates, gaps
    offer(OP_REMOVE, 32'd5,         32'hFFFF_FFFF);  // remove from empty table
    offer(OP_INSERT, 32'h0,         32'h0);
    offer(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(OP_INSERT, 32'h8000_0000, 32'h5555_5555);
    offer(OP_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    offer(OP_INSERT, 32'h0,         32'h1234_5678);  // duplicate at head
    offer(OP_INSERT, 32'hFFFF_FFFF, 32'h0);          // duplicate at tail
    offer(OP_INSERT, 32'h1,         32'h1);
    offer(OP_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    offer(OP_REMOVE, 32'h8000_0001, 32'h0);          // absent, between entries
    offer(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    offer(OP_REMOVE, 32'h0,         32'h0);
    offer(OP_REMOVE, 32'h0,         32'h0);          // already gone
    offer(OP_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    offer(OP_INSERT, 32'h7FFF_FFFF, 32'h0);
    offer(OP_REMOVE, 32'h1,         32'h0);
    offer(OP_REMOVE, 32'h8000_0000, 32'h0);
    offer(OP_REMOVE, 32'h7FFF_FFFF, 32'h0);
    offer(OP_REMOVE, 32'hFFFF_FFFE, 32'h0);          // back to empty

    // random: walk the key pool so fills reach full and drains reach empty
    for (p = 0; p < 8; p++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      idx = $urandom_range(0, POOL - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        case (plan[p])
          PH_FILL:  op = (r < 85) ? OP_INSERT : OP_REMOVE;
          PH_DRAIN: op = (r < 85) ? OP_REMOVE : OP_INSERT;
          default:  op = (r < 50) ? OP_INSERT : OP_REMOVE;
        endcase
        // fresh keys only on removes, or they would never leave the table
        if (op == OP_REMOVE && $urandom_range(0, 9) == 0) begin
          key = $urandom;
        end else begin
          key = key_pool[idx];
          idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, POOL - 1) : (idx + 1) % POOL;
        end
        if ($urandom_range(0, 15) == 0)
          edge_id = r[0] ? '1 : '0;
        else
          edge_id = $urandom;
        offer(op, key, edge_id);
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d inserted, %0d duplicates, %0d removed, %0d not found, %0d dropped full",
             accepted_in, n_inserted, n_duplicate, n_removed, n_not_found, n_full);
    $display("Peak occupancy %0d of %0d entries; output held off %0d cycles under load",
             peak_fill, DEPTH, HOLD_OFF);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/sat_pkg.sv
src/sat_cell.sv
src/sat_ctrl.sv
src/sorted_adjacency_table.sv
sim/adjacency_table_checker.sv
sim/sorted_adjacency_table_tb.sv
